>>> hw/rtl/ikhu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ikhu_pkg: shared types and constants of the integer key hash unit
// Hash constants, core index and key width codes, and the core result type.
// ----------------------------------------------------------------------------
package ikhu_pkg;

	// Multiplicative hash constant (golden ratio) and its low halfword
	localparam logic [31:0] KNUTH_MUL    = 32'h9E37_79B1;
	localparam logic [15:0] KNUTH_MUL_LO = 16'h79B1;

	// Six-step mix constants
	localparam logic [31:0] JMIX_C1 = 32'h7ed5_5d16;
	localparam logic [31:0] JMIX_C2 = 32'hc761_c23c;
	localparam logic [31:0] JMIX_C3 = 32'h1656_67b1;
	localparam logic [31:0] JMIX_C4 = 32'hd3a2_646c;
	localparam logic [31:0] JMIX_C5 = 32'hfd70_46c5;
	localparam logic [31:0] JMIX_C6 = 32'hb55a_4f09;

	// Core hash index (3 bits, same coding as the opcode for keys wider than 8 bits)
	localparam logic [2:0] IDX_MULT    = 3'd0;
	localparam logic [2:0] IDX_JMIX    = 3'd1;
	localparam logic [2:0] IDX_WMIX    = 3'd2;
	localparam logic [2:0] IDX_STRING0 = 3'd3;
	localparam logic [2:0] IDX_STRING1 = 3'd4;

	// Opcodes with a special meaning for narrow keys
	localparam logic [2:0] OP_FIRST  = 3'd0;
	localparam logic [2:0] OP_SECOND = 3'd1;

	// Key width codes
	localparam logic [1:0] KW_8  = 2'd0;
	localparam logic [1:0] KW_16 = 2'd1;
	localparam logic [1:0] KW_32 = 2'd2;
	localparam logic [1:0] KW_64 = 2'd3;

	// Result of one 32-bit hash core
	typedef struct packed {
		logic [31:0] hash;
		logic        str_hit;
	} core_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/ikhu_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ikhu_core: 32-bit hash core
// Multiplicative hash, six-step add/xor mix or shift/xor mix of one word,
// selected by the core index. String hash indices raise str_hit.
// ----------------------------------------------------------------------------
module ikhu_core (
	input  wire logic [31:0]        value,
	input  wire logic [2:0]         idx,
	output ikhu_pkg::core_res_t     res
);

	logic [63:0] mult_prod;
	logic [31:0] j1, j2, j3, j4, j5, j6;
	logic [31:0] w1, w2, w3, w4, w5, w6;

	// Multiplicative: bits 47..16 of value * constant
	assign mult_prod = {32'h0, value} * {32'h0, ikhu_pkg::KNUTH_MUL};

	// Six-step add/xor mix
	always_comb begin
		j1 = (value + ikhu_pkg::JMIX_C1) + (value << 12);
		j2 = (j1 ^ ikhu_pkg::JMIX_C2) ^ (j1 >> 19);
		j3 = (j2 + ikhu_pkg::JMIX_C3) + (j2 << 5);
		j4 = (j3 + ikhu_pkg::JMIX_C4) ^ (j3 << 9);
		j5 = (j4 + ikhu_pkg::JMIX_C5) + (j4 << 3);
		j6 = (j5 ^ ikhu_pkg::JMIX_C6) ^ (j5 >> 16);
	end

	// Shift/xor mix; the multiply by 2057 is 1 + 8 + 2048
	always_comb begin
		w1 = (~value) + (value << 15);
		w2 = w1 ^ (w1 >> 12);
		w3 = w2 + (w2 << 2);
		w4 = w3 ^ (w3 >> 4);
		w5 = w4 + (w4 << 3) + (w4 << 11);
		w6 = w5 ^ (w5 >> 16);
	end

	// Index select
	always_comb begin
		res.hash    = 32'h0;
		res.str_hit = 1'b0;
		case (idx)
			ikhu_pkg::IDX_MULT:    res.hash = mult_prod[47:16];
			ikhu_pkg::IDX_JMIX:    res.hash = j6;
			ikhu_pkg::IDX_WMIX:    res.hash = w6;
			ikhu_pkg::IDX_STRING0: res.str_hit = 1'b1;
			ikhu_pkg::IDX_STRING1: res.str_hit = 1'b1;
			default:               res.hash = 32'h0;
		endcase
	end

endmodule
`default_nettype wire

>>> hw/rtl/integer_key_hash_unit_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_key_hash_unit_core: integer key hash unit, top level
// Hashes an 8/16/32/64-bit key with a selectable integer hash and masks it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries key_value, key_width and
//   opcode; output channel (out_valid / out_stall) returns hash_out and
//   unsupported, one result transaction per input transaction, in order.
//   A transaction completes on a clock edge with valid high and stall low.
//   The input register feeds the hash logic, which feeds the result register;
//   throughput is one key per cycle while out_stall is low, set by the
//   single registered pass through two parallel hash cores (low and high
//   key halves). When the receiver stalls, the result register holds and
//   the input register still fills once; in_stall rises only when both are
//   full. hash_mask is written with cfg_wr_en / cfg_wr_data while the unit
//   is idle, a rule for the user that the block does not enforce. Reset
//   (arst_n low) empties both registers and sets hash_mask to all ones.
// ----------------------------------------------------------------------------
module integer_key_hash_unit_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] key_value,
	input  wire logic [1:0]  key_width,
	input  wire logic [2:0]  opcode,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      hash_out,
	output logic             unsupported
);

	logic [31:0] hash_mask_q;

	logic        valid_s1;
	logic [63:0] key_s1;
	logic [1:0]  width_s1;
	logic [2:0]  op_s1;

	logic        valid_s2;
	logic [31:0] hash_s2;
	logic        unsup_s2;

	logic        adv;
	logic        take_in;

	logic [31:0] lo_value;
	logic [2:0]  lo_idx;
	logic [31:0] mult_hi_prod;
	logic [31:0] raw_hash;
	logic        str_flag;
	ikhu_pkg::core_res_t lo_res;
	ikhu_pkg::core_res_t hi_res;

	// Mask register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mask_q <= 32'hFFFF_FFFF;
		end else if (cfg_wr_en) begin
			hash_mask_q <= cfg_wr_data;
		end
	end

	// Handshake: stage 2 advances when empty or drained
	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign take_in  = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			key_s1   <= key_value;
			width_s1 <= key_width;
			op_s1    <= opcode;
		end
	end

	// Low core operand and index per key width
	always_comb begin
		lo_value = key_s1[31:0];
		lo_idx   = op_s1;
		case (width_s1)
			ikhu_pkg::KW_8: begin
				if (op_s1 == ikhu_pkg::OP_FIRST || op_s1 == ikhu_pkg::OP_SECOND) begin
					lo_value = {24'h0, key_s1[7:0]};
				end else begin
					lo_value = {4{key_s1[7:0]}};
				end
				if (op_s1 != ikhu_pkg::OP_FIRST) begin
					lo_idx = op_s1 - 3'd1;
				end
			end
			ikhu_pkg::KW_16: begin
				if (op_s1 == ikhu_pkg::OP_FIRST) begin
					lo_value = {16'h0, key_s1[15:0]};
				end else begin
					lo_value = {2{key_s1[15:0]}};
				end
			end
			default: lo_value = key_s1[31:0];
		endcase
	end

	ikhu_core u_core_lo (
		.value (lo_value),
		.idx   (lo_idx),
		.res   (lo_res)
	);

	ikhu_core u_core_hi (
		.value (key_s1[63:32]),
		.idx   (op_s1),
		.res   (hi_res)
	);

	// 64-bit multiplicative: key bits 47..32 add into product bits 47..32
	assign mult_hi_prod = {16'h0, key_s1[47:32]} * {16'h0, ikhu_pkg::KNUTH_MUL_LO};

	// Combine per key width
	always_comb begin
		raw_hash = lo_res.hash;
		str_flag = lo_res.str_hit;
		case (width_s1)
			ikhu_pkg::KW_8: begin
				if (op_s1 == ikhu_pkg::OP_FIRST) begin
					raw_hash = {24'h0, key_s1[7:0]};
				end
			end
			ikhu_pkg::KW_64: begin
				if (op_s1 == ikhu_pkg::OP_FIRST) begin
					raw_hash = lo_res.hash + {mult_hi_prod[15:0], 16'h0};
				end else begin
					raw_hash = lo_res.hash ^ hi_res.hash;
					str_flag = lo_res.str_hit | hi_res.str_hit;
				end
			end
			default: raw_hash = lo_res.hash;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			hash_s2  <= str_flag ? 32'h0 : (raw_hash & hash_mask_q);
			unsup_s2 <= str_flag;
		end
	end

	assign out_valid   = valid_s2;
	assign hash_out    = hash_s2;
	assign unsupported = unsup_s2;

endmodule
`default_nettype wire

>>> tb/sv/integer_key_hash_unit_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_key_hash_unit_core_tb: self-checking bench for the integer key hash unit
// Drives keys of every width and hash index through the valid/stall channels,
// predicts each masked hash in the bench and compares it with every result
// transaction in order. Covers reset mask, mask extremes and random traffic
// under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module integer_key_hash_unit_core_tb;

	localparam logic [31:0] WMIX_MUL       = 32'd2057;
	localparam int          CYCLE_LIMIT    = 400000;
	localparam int          ITEMS_PER_MASK = 90;
	localparam int          MASKS_PER_MIX  = 5;
	localparam int          DRAIN_CYCLES   = 6;

	typedef struct packed {
		logic [31:0] hash;
		logic        unsup;
	} hash_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [31:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] key_value = '0;
	logic [1:0]  key_width = ikhu_pkg::KW_8;
	logic [2:0]  opcode = ikhu_pkg::OP_FIRST;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] hash_out;
	logic        unsupported;

	// Bench copy of the mask register and the queue of hashes still owed
	logic [31:0]  mask_shadow = 32'hFFFF_FFFF;
	hash_result_t pending_hashes[$];
	int           error_count = 0;
	int           cycle_count = 0;
	int           send_gap_pct = 0;
	int           recv_stall_pct = 0;

	integer_key_hash_unit_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.key_value   (key_value),
		.key_width   (key_width),
		.opcode      (opcode),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hash_out    (hash_out),
		.unsupported (unsupported)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// Hash prediction
	// ------------------------------------------------------------------------

	// Multiplicative hash: bits 47..16 of the 64-bit product
	function automatic logic [31:0] mult_bits(logic [63:0] v);
		logic [63:0] prod;
		prod = v * {32'd0, ikhu_pkg::KNUTH_MUL};
		return prod[47:16];
	endfunction

	function automatic logic [31:0] six_step_mix(logic [31:0] v);
		v = (v + ikhu_pkg::JMIX_C1) + (v << 12);
		v = (v ^ ikhu_pkg::JMIX_C2) ^ (v >> 19);
		v = (v + ikhu_pkg::JMIX_C3) + (v << 5);
		v = (v + ikhu_pkg::JMIX_C4) ^ (v << 9);
		v = (v + ikhu_pkg::JMIX_C5) + (v << 3);
		v = (v ^ ikhu_pkg::JMIX_C6) ^ (v >> 16);
		return v;
	endfunction

	function automatic logic [31:0] shift_mul_mix(logic [31:0] v);
		v = (~v) + (v << 15);
		v = v ^ (v >> 12);
		v = v + (v << 2);
		v = v ^ (v >> 4);
		v = v * WMIX_MUL;
		v = v ^ (v >> 16);
		return v;
	endfunction

	// 32-bit core selected by index; string indices only raise the flag
	function automatic ikhu_pkg::core_res_t hash32_by_index(logic [31:0] v, logic [2:0] idx);
		ikhu_pkg::core_res_t res;
		res = '0;
		case (idx)
			ikhu_pkg::IDX_MULT: res.hash = mult_bits({32'd0, v});
			ikhu_pkg::IDX_JMIX: res.hash = six_step_mix(v);
			ikhu_pkg::IDX_WMIX: res.hash = shift_mul_mix(v);
			ikhu_pkg::IDX_STRING0, ikhu_pkg::IDX_STRING1: res.str_hit = 1'b1;
			default: res = '0;
		endcase
		return res;
	endfunction

	function automatic hash_result_t predict_masked_hash(logic [63:0] k, logic [1:0] w,
			logic [2:0] op);
		hash_result_t        exp_res;
		ikhu_pkg::core_res_t lo_res;
		ikhu_pkg::core_res_t hi_res;
		logic [31:0]         h;
		logic                hit;
		h = '0;
		hit = 1'b0;
		case (w)
			ikhu_pkg::KW_8: begin
				if (op == ikhu_pkg::OP_FIRST) begin
					h = {24'd0, k[7:0]};
				end else if (op == ikhu_pkg::OP_SECOND) begin
					h = mult_bits({56'd0, k[7:0]});
				end else begin
					lo_res = hash32_by_index({4{k[7:0]}}, op - 3'd1);
					h = lo_res.hash;
					hit = lo_res.str_hit;
				end
			end
			ikhu_pkg::KW_16: begin
				if (op == ikhu_pkg::OP_FIRST) begin
					h = mult_bits({48'd0, k[15:0]});
				end else begin
					lo_res = hash32_by_index({2{k[15:0]}}, op);
					h = lo_res.hash;
					hit = lo_res.str_hit;
				end
			end
			ikhu_pkg::KW_32: begin
				lo_res = hash32_by_index(k[31:0], op);
				h = lo_res.hash;
				hit = lo_res.str_hit;
			end
			default: begin
				if (op == ikhu_pkg::OP_FIRST) begin
					h = mult_bits(k);
				end else begin
					lo_res = hash32_by_index(k[31:0], op);
					hi_res = hash32_by_index(k[63:32], op);
					h = lo_res.hash ^ hi_res.hash;
					hit = lo_res.str_hit | hi_res.str_hit;
				end
			end
		endcase
		exp_res.hash = hit ? 32'd0 : (h & mask_shadow);
		exp_res.unsup = hit;
		return exp_res;
	endfunction

	// ------------------------------------------------------------------------
	// Receiver stall, result checking and watchdog
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		hash_result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_hashes.size() == 0) begin
				$error("result transaction with none expected: hash_out %h unsupported %b",
					hash_out, unsupported);
				error_count++;
			end else begin
				exp_res = pending_hashes.pop_front();
				if (hash_out !== exp_res.hash) begin
					$error("hash_out: expected %h, got %h", exp_res.hash, hash_out);
					error_count++;
				end
				if (unsupported !== exp_res.unsup) begin
					$error("unsupported: expected %b, got %b", exp_res.unsup, unsupported);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("integer_key_hash_unit_core test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Shared drivers
	// ------------------------------------------------------------------------

	// Offer one key, hold it until accepted, then log the expected hash
	task automatic send_key(logic [63:0] k, logic [1:0] w, logic [2:0] op);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		key_value <= k;
		key_width <= w;
		opcode <= op;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_hashes.push_back(predict_masked_hash(k, w, op));
	endtask

	// Stop sending, wait for every owed result, then wait out DRAIN_CYCLES
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_hashes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mask write, only with the unit idle
	task automatic write_mask(logic [31:0] m);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mask_shadow = m;
	endtask

	function automatic logic [63:0] random_key();
		case ($urandom_range(7))
			0: return 64'd0;
			1: return {64{1'b1}};
			2: return 64'd1 << $urandom_range(63);
			3: return ~(64'd1 << $urandom_range(63));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Each width against special opcodes, string and out-of-range indices
	task automatic test_width_and_index_map();
		send_key({64{1'b1}}, ikhu_pkg::KW_8, ikhu_pkg::OP_FIRST);
		// unused bits ignored
		send_key(64'hFFFF_FFFF_FFFF_FF00, ikhu_pkg::KW_8, ikhu_pkg::OP_FIRST);
		send_key(64'h0000_0000_0000_00A5, ikhu_pkg::KW_8, ikhu_pkg::OP_SECOND);
		send_key({64{1'b1}}, ikhu_pkg::KW_8, 3'd2);
		send_key(64'h0000_0000_0000_0080, ikhu_pkg::KW_8, 3'd3);
		send_key(64'h0000_0000_0000_0011, ikhu_pkg::KW_8, 3'd4);        // string hash
		send_key(64'h0000_0000_0000_0011, ikhu_pkg::KW_8, 3'd5);        // string hash
		send_key(64'h0000_0000_0000_00FF, ikhu_pkg::KW_8, 3'd7);        // past every hash
		send_key({64{1'b1}}, ikhu_pkg::KW_16, ikhu_pkg::OP_FIRST);
		send_key(64'hFFFF_FFFF_FFFF_0000, ikhu_pkg::KW_16, 3'd1);
		send_key(64'h0000_0000_0000_8001, ikhu_pkg::KW_16, 3'd2);
		send_key(64'h0000_0000_0000_1234, ikhu_pkg::KW_16, ikhu_pkg::IDX_STRING0);
		send_key(64'h0000_0000_0000_FFFF, ikhu_pkg::KW_16, 3'd6);
		send_key({64{1'b1}}, ikhu_pkg::KW_32, ikhu_pkg::IDX_MULT);
		send_key(64'd0, ikhu_pkg::KW_32, ikhu_pkg::IDX_JMIX);
		send_key(64'hDEAD_BEEF_8000_0001, ikhu_pkg::KW_32, ikhu_pkg::IDX_WMIX);
		send_key(64'h0000_0000_CAFE_F00D, ikhu_pkg::KW_32, ikhu_pkg::IDX_STRING1);
		send_key({64{1'b1}}, ikhu_pkg::KW_64, ikhu_pkg::IDX_MULT);
		send_key(64'h8000_0000_0000_0001, ikhu_pkg::KW_64, ikhu_pkg::IDX_JMIX);
		send_key({64{1'b1}}, ikhu_pkg::KW_64, ikhu_pkg::IDX_WMIX);
		send_key(64'h0123_4567_89AB_CDEF, ikhu_pkg::KW_64, ikhu_pkg::IDX_STRING0);
		send_key(64'h0123_4567_89AB_CDEF, ikhu_pkg::KW_64, 3'd7);
	endtask

	// Zero mask clears every hash; the string flag still shows
	task automatic test_zero_mask();
		write_mask(32'd0);
		send_key(64'h0000_0000_0000_00FF, ikhu_pkg::KW_8, ikhu_pkg::OP_FIRST);
		send_key({64{1'b1}}, ikhu_pkg::KW_64, ikhu_pkg::IDX_WMIX);
		send_key(64'h0000_0000_1111_2222, ikhu_pkg::KW_32, ikhu_pkg::IDX_STRING1);
	endtask

	// Random keys under several masks, for one sender/receiver idling mix
	task automatic test_random_traffic(int gap_pct, int stall_pct);
		logic [31:0] m;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		for (int s = 0; s < MASKS_PER_MIX; s++) begin
			case (s)
				0: m = 32'hFFFF_FFFF;
				1: m = (32'd1 << $urandom_range(1, 31)) - 32'd1;
				2: m = 32'd0;
				3: m = $urandom;
				default: m = 32'hFFFF_0000;
			endcase
			write_mask(m);
			for (int i = 0; i < ITEMS_PER_MASK; i++) begin
				send_key(random_key(), 2'($urandom_range(3)), 3'($urandom_range(7)));
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_width_and_index_map();
		test_zero_mask();
		test_random_traffic(9, 68);
		test_random_traffic(68, 9);
		test_random_traffic(0, 0);

		drain_results();
		if (error_count == 0) begin
			$display("integer_key_hash_unit_core test passed");
		end else begin
			$display("integer_key_hash_unit_core test failed");
		end
		$finish;
	end

endmodule
